>>> rtl/kmec_pkg.sv
// shared types and constants for the keyboard modifier edge counter
package kmec_pkg;

  localparam int unsigned CTRL_BIT  = 4;
  localparam int unsigned SHIFT_BIT = 5;

  typedef enum logic {
    REQ_FRAME = 1'b0,
    REQ_READ  = 1'b1
  } kmec_req_e;

  typedef enum logic [1:0] {
    GRP_PLAIN = 2'd0,
    GRP_CTRL  = 2'd1,
    GRP_SHIFT = 2'd2
  } kmec_group_e;

  // request as it arrives on the input channel
  typedef struct packed {
    logic               req_type;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] mouse_wheel;
    logic               left_down;
    logic               right_down;
    logic [15:0]        key_mask;
    logic [1:0]         read_group;
    logic [3:0]         read_key;
  } kmec_req_t;

  // result as it leaves on the output channel
  typedef struct packed {
    logic signed [15:0] out_dx;
    logic signed [15:0] out_dy;
    logic signed [15:0] out_wheel;
    logic               out_left;
    logic               out_right;
    logic [15:0]        plain_keys;
    logic [15:0]        ctrl_keys;
    logic [15:0]        shift_keys;
    logic [15:0]        plain_edges;
    logic [15:0]        ctrl_edges;
    logic [15:0]        shift_edges;
    logic [15:0]        count_value;
  } kmec_rsp_t;

  // classified request handed from the front end to the back end
  typedef struct packed {
    logic               is_read;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic signed [15:0] mouse_wheel;
    logic               left_down;
    logic               right_down;
    logic [15:0]        plain_keys;
    logic [15:0]        ctrl_keys;
    logic [15:0]        shift_keys;
    logic [1:0]         read_group;
    logic [3:0]         read_key;
  } kmec_cls_t;

endpackage

>>> rtl/kmec_if.sv
// valid/ready channel interfaces for requests and results

interface kmec_in_if;
  logic                valid;
  logic                ready;
  kmec_pkg::kmec_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface kmec_out_if;
  logic                valid;
  logic                ready;
  kmec_pkg::kmec_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/keyboard_modifier_edge_counter_top.sv
// top level of the keyboard modifier edge counter
// a request accepted is registered in the queue, then in the result register
// throughput: one request per cycle while the queue has room; the two-entry queue
//   decouples the input side from the back end, which waits on the result register
// reset: previous group masks and all press counters clear at once, queue and
//   result register come up empty; no clearing pass, requests taken right after reset
module keyboard_modifier_edge_counter_top #(
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  kmec_in_if.sink           in_i,
  kmec_out_if.source        out_o
);

  localparam int unsigned Q_W = $bits(kmec_pkg::kmec_cls_t) + 3 * KEY_BITS;

  // front end outputs
  kmec_pkg::kmec_cls_t  f_cls;
  logic [KEY_BITS-1:0]  f_e_plain, f_e_ctrl, f_e_shift;
  logic                 in_accept;

  // queue outputs
  logic                 q_valid, q_ready;
  logic [Q_W-1:0]       q_wdata, q_rdata;

  // back end view of the queue head
  kmec_pkg::kmec_cls_t  b_cls;
  logic [KEY_BITS-1:0]  b_e_plain, b_e_ctrl, b_e_shift;
  logic                 fifo_ready;

  // a request is taken whenever the queue has room
  assign in_i.ready = fifo_ready;
  assign in_accept  = in_i.valid && fifo_ready;

  // group masks and rising edges, previous masks updated on accept of a frame
  kmec_front #(
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (in_i.payload),
    .accept_i  (in_accept),
    .cls_o     (f_cls),
    .e_plain_o (f_e_plain),
    .e_ctrl_o  (f_e_ctrl),
    .e_shift_o (f_e_shift)
  );

  assign q_wdata = {f_e_plain, f_e_ctrl, f_e_shift, f_cls};

  // decouples classification from counting, keeps request order
  kmec_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_i.valid),
    .push_ready_o (fifo_ready),
    .push_data_i  (q_wdata),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_rdata)
  );

  assign {b_e_plain, b_e_ctrl, b_e_shift, b_cls} = q_rdata;

  // counter updates and reads happen in queue order, so a read sees every
  // earlier frame's increments
  kmec_back #(
    .KEY_BITS    (KEY_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .ready_o     (q_ready),
    .cls_i       (b_cls),
    .e_plain_i   (b_e_plain),
    .e_ctrl_i    (b_e_ctrl),
    .e_shift_i   (b_e_shift),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_rsp_o   (out_o.payload)
  );

endmodule

>>> rtl/kmec_front.sv
// front end: key group forming and rising edge detection per frame
module kmec_front #(
  parameter int unsigned KEY_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kmec_pkg::kmec_req_t       req_i,
  input  logic                      accept_i,
  output kmec_pkg::kmec_cls_t       cls_o,
  output logic [KEY_BITS-1:0]       e_plain_o,
  output logic [KEY_BITS-1:0]       e_ctrl_o,
  output logic [KEY_BITS-1:0]       e_shift_o
);

  logic [KEY_BITS-1:0] prev_plain_q, prev_plain_d;
  logic [KEY_BITS-1:0] prev_ctrl_q, prev_ctrl_d;
  logic [KEY_BITS-1:0] prev_shift_q, prev_shift_d;
  logic [KEY_BITS-1:0] now, ctrl_grp, shift_grp, keep;
  logic                is_read;

  assign is_read   = (req_i.req_type == kmec_pkg::REQ_READ);
  assign now       = KEY_BITS'(req_i.key_mask);
  assign ctrl_grp  = now[kmec_pkg::CTRL_BIT] ? now : '0;
  assign shift_grp = now[kmec_pkg::SHIFT_BIT] ? now : '0;
  // modifier bits themselves never count
  assign keep      = ~((KEY_BITS'(1) << kmec_pkg::CTRL_BIT) |
                       (KEY_BITS'(1) << kmec_pkg::SHIFT_BIT));

  always_comb begin
    e_plain_o = '0;
    e_ctrl_o  = '0;
    e_shift_o = '0;
    cls_o     = '0;
    cls_o.is_read    = is_read;
    cls_o.read_group = req_i.read_group;
    cls_o.read_key   = req_i.read_key;
    if (!is_read) begin
      e_plain_o = now & ~prev_plain_q & ~ctrl_grp & ~shift_grp & keep;
      e_ctrl_o  = ctrl_grp & ~prev_ctrl_q & keep;
      e_shift_o = shift_grp & ~prev_shift_q & keep;
      cls_o.mouse_dx    = req_i.mouse_dx;
      cls_o.mouse_dy    = req_i.mouse_dy;
      cls_o.mouse_wheel = req_i.mouse_wheel;
      cls_o.left_down   = req_i.left_down;
      cls_o.right_down  = req_i.right_down;
      cls_o.plain_keys  = 16'(now);
      cls_o.ctrl_keys   = 16'(ctrl_grp);
      cls_o.shift_keys  = 16'(shift_grp);
    end
  end

  always_comb begin
    prev_plain_d = prev_plain_q;
    prev_ctrl_d  = prev_ctrl_q;
    prev_shift_d = prev_shift_q;
    if (accept_i && !is_read) begin
      prev_plain_d = now;
      prev_ctrl_d  = ctrl_grp;
      prev_shift_d = shift_grp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_plain_q <= '0;
      prev_ctrl_q  <= '0;
      prev_shift_q <= '0;
    end else begin
      prev_plain_q <= prev_plain_d;
      prev_ctrl_q  <= prev_ctrl_d;
      prev_shift_q <= prev_shift_d;
    end
  end

endmodule

>>> rtl/kmec_fifo.sv
// two-entry queue between front end and back end
module kmec_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/kmec_back.sv
// back end: press counters, counter reads and the result register
module kmec_back #(
  parameter int unsigned KEY_BITS    = 16,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  kmec_pkg::kmec_cls_t  cls_i,
  input  logic [KEY_BITS-1:0]  e_plain_i,
  input  logic [KEY_BITS-1:0]  e_ctrl_i,
  input  logic [KEY_BITS-1:0]  e_shift_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kmec_pkg::kmec_rsp_t  out_rsp_o
);

  localparam int unsigned KIW       = $clog2(KEY_BITS);
  localparam int unsigned KEY_EXT_W = KIW + 4;

  logic [COUNT_WIDTH-1:0] cnt_plain_q [KEY_BITS];
  logic [COUNT_WIDTH-1:0] cnt_ctrl_q  [KEY_BITS];
  logic [COUNT_WIDTH-1:0] cnt_shift_q [KEY_BITS];

  logic                   out_valid_q, out_valid_d;
  kmec_pkg::kmec_rsp_t    rsp_q, rsp_d;
  logic                   pop;
  logic [KEY_EXT_W-1:0]   key_ext;
  logic [KIW-1:0]         rd_idx;
  logic                   key_ok;
  logic [COUNT_WIDTH-1:0] rd_cnt;

  assign ready_o = !out_valid_q || out_ready_i;
  assign pop     = valid_i && ready_o;

  // counter read for a read request
  assign key_ext = KEY_EXT_W'(cls_i.read_key);
  assign rd_idx  = key_ext[KIW-1:0];
  assign key_ok  = (key_ext < KEY_EXT_W'(KEY_BITS));

  always_comb begin
    rd_cnt = '0;
    if (key_ok) begin
      unique case (cls_i.read_group)
        kmec_pkg::GRP_PLAIN: rd_cnt = cnt_plain_q[rd_idx];
        kmec_pkg::GRP_CTRL:  rd_cnt = cnt_ctrl_q[rd_idx];
        kmec_pkg::GRP_SHIFT: rd_cnt = cnt_shift_q[rd_idx];
        default:             rd_cnt = '0;
      endcase
    end
  end

  always_comb begin
    rsp_d             = '0;
    rsp_d.out_dx      = cls_i.mouse_dx;
    rsp_d.out_dy      = cls_i.mouse_dy;
    rsp_d.out_wheel   = cls_i.mouse_wheel;
    rsp_d.out_left    = cls_i.left_down;
    rsp_d.out_right   = cls_i.right_down;
    rsp_d.plain_keys  = cls_i.plain_keys;
    rsp_d.ctrl_keys   = cls_i.ctrl_keys;
    rsp_d.shift_keys  = cls_i.shift_keys;
    rsp_d.plain_edges = 16'(e_plain_i);
    rsp_d.ctrl_edges  = 16'(e_ctrl_i);
    rsp_d.shift_edges = 16'(e_shift_i);
    rsp_d.count_value = cls_i.is_read ? 16'(rd_cnt) : 16'd0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // one incrementer per counter, enabled by its edge bit when the queue head is popped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_BITS; k++) begin
        cnt_plain_q[k] <= '0;
        cnt_ctrl_q[k]  <= '0;
        cnt_shift_q[k] <= '0;
      end
    end else if (pop) begin
      for (int k = 0; k < KEY_BITS; k++) begin
        if (e_plain_i[k]) cnt_plain_q[k] <= cnt_plain_q[k] + COUNT_WIDTH'(1);
        if (e_ctrl_i[k])  cnt_ctrl_q[k]  <= cnt_ctrl_q[k] + COUNT_WIDTH'(1);
        if (e_shift_i[k]) cnt_shift_q[k] <= cnt_shift_q[k] + COUNT_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

>>> verif/testbench.sv
// self-checking testbench for the keyboard modifier edge counter top level
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned NUM_KEYS = 16;
  // every key bit except the two modifiers can count presses
  localparam logic [15:0] COUNTED_KEYS = ~((16'h1 << kmec_pkg::CTRL_BIT) |
                                           (16'h1 << kmec_pkg::SHIFT_BIT));
  localparam logic [15:0] ALL_KEYS     = COUNTED_KEYS;
  localparam logic [15:0] MODS_AND_ALL = 16'hFFFF;
  localparam logic [15:0] NO_KEYS      = 16'h0000;

  // one request waiting to be sent, with its pacing hints
  typedef struct {
    kmec_pkg::kmec_req_t rq;
    bit        drain;  // hold off until every result so far has come back
    bit        calm;   // no idling on either side while this one is in play
  } pending_t;

  logic clk_i;
  logic rst_ni;

  kmec_in_if  req_ch ();
  kmec_out_if rsp_ch ();

  keyboard_modifier_edge_counter_top #(
    .KEY_BITS    (16),
    .COUNT_WIDTH (16)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  // requests still to send and results still owed by the block
  pending_t            request_q[$];
  kmec_pkg::kmec_rsp_t report_q[$];

  // keyboard state as the block should hold it
  logic [15:0] last_plain;
  logic [15:0] last_ctrl;
  logic [15:0] last_shift;
  logic [15:0] press_cnt [0:47];

  int errors;

  // pacing state of the driver and the receiving side
  int unsigned src_gap;
  int unsigned src_chance;
  int unsigned sink_gap;
  int unsigned sink_chance;
  int unsigned pace_cycle;
  logic        calm_now;

  kmec_pkg::kmec_rsp_t want;

  // ---------------------------------------------------------------------------
  // expected result of one request; frames also advance the keyboard state
  // ---------------------------------------------------------------------------
  function automatic kmec_pkg::kmec_rsp_t next_report(kmec_pkg::kmec_req_t rq);
    kmec_pkg::kmec_rsp_t rs;
    logic [15:0] now;
    logic [15:0] ctl;
    logic [15:0] sft;
    logic [15:0] e_plain;
    logic [15:0] e_ctrl;
    logic [15:0] e_shift;
    logic [3:0]  kk;
    rs = '0;
    if (rq.req_type == kmec_pkg::REQ_READ) begin
      // read requests leave the state alone; group three does not exist
      if (rq.read_group <= kmec_pkg::GRP_SHIFT) begin
        rs.count_value = press_cnt[{rq.read_group, rq.read_key}];
      end
      return rs;
    end
    now = rq.key_mask;
    ctl = now[kmec_pkg::CTRL_BIT]  ? now : NO_KEYS;
    sft = now[kmec_pkg::SHIFT_BIT] ? now : NO_KEYS;
    // a plain press only counts when no modifier claims the key
    e_plain = now & ~last_plain & ~ctl & ~sft & COUNTED_KEYS;
    e_ctrl  = ctl & ~last_ctrl & COUNTED_KEYS;
    e_shift = sft & ~last_shift & COUNTED_KEYS;
    for (int k = 0; k < NUM_KEYS; k++) begin
      kk = k[3:0];
      // counters are 16 bits wide and simply wrap
      if (e_plain[k]) begin
        press_cnt[{kmec_pkg::GRP_PLAIN, kk}] = press_cnt[{kmec_pkg::GRP_PLAIN, kk}] + 16'd1;
      end
      if (e_ctrl[k]) begin
        press_cnt[{kmec_pkg::GRP_CTRL, kk}] = press_cnt[{kmec_pkg::GRP_CTRL, kk}] + 16'd1;
      end
      if (e_shift[k]) begin
        press_cnt[{kmec_pkg::GRP_SHIFT, kk}] = press_cnt[{kmec_pkg::GRP_SHIFT, kk}] + 16'd1;
      end
    end
    last_plain = now;
    last_ctrl  = ctl;
    last_shift = sft;
    rs.out_dx      = rq.mouse_dx;
    rs.out_dy      = rq.mouse_dy;
    rs.out_wheel   = rq.mouse_wheel;
    rs.out_left    = rq.left_down;
    rs.out_right   = rq.right_down;
    rs.plain_keys  = now;
    rs.ctrl_keys   = ctl;
    rs.shift_keys  = sft;
    rs.plain_edges = e_plain;
    rs.ctrl_edges  = e_ctrl;
    rs.shift_edges = e_shift;
    return rs;
  endfunction

  // request with every field random, including group three on reads
  function automatic kmec_pkg::kmec_req_t rand_req();
    kmec_pkg::kmec_req_t rq;
    rq.req_type    = 1'($urandom_range(1));
    rq.mouse_dx    = 16'($urandom);
    rq.mouse_dy    = 16'($urandom);
    rq.mouse_wheel = 16'($urandom);
    rq.left_down   = 1'($urandom_range(1));
    rq.right_down  = 1'($urandom_range(1));
    rq.key_mask    = 16'($urandom);
    rq.read_group  = 2'($urandom_range(3));
    rq.read_key    = 4'($urandom_range(15));
    return rq;
  endfunction

  function automatic kmec_pkg::kmec_req_t frame_req(logic [15:0] mask);
    kmec_pkg::kmec_req_t rq;
    rq          = rand_req();
    rq.req_type = kmec_pkg::REQ_FRAME;
    rq.key_mask = mask;
    return rq;
  endfunction

  // the unused frame fields of a read carry random junk on purpose
  function automatic kmec_pkg::kmec_req_t read_req(logic [1:0] grp, logic [3:0] key);
    kmec_pkg::kmec_req_t rq;
    rq            = rand_req();
    rq.req_type   = kmec_pkg::REQ_READ;
    rq.read_group = grp;
    rq.read_key   = key;
    return rq;
  endfunction

  task automatic send(kmec_pkg::kmec_req_t rq, bit drain = 1'b0, bit calm = 1'b0);
    pending_t p;
    p.rq    = rq;
    p.drain = drain;
    p.calm  = calm;
    request_q.push_back(p);
  endtask

  task automatic check_field(string name, logic [15:0] exp, logic [15:0] got);
    if (exp !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset and known values on every input from time zero
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni         = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    errors      = 0;
    last_plain  = '0;
    last_ctrl   = '0;
    last_shift  = '0;
    foreach (press_cnt[i]) press_cnt[i] = '0;
    src_gap     = 0;
    src_chance  = 10;
    sink_gap    = 0;
    sink_chance = 10;
    pace_cycle  = 0;
    calm_now    = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // driver: offers the oldest pending request, holds it until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      pace_cycle++;
      // every so often change how busy both sides are, zero means no idling
      if (pace_cycle % 64 == 0) begin
        case ($urandom_range(2))
          0: src_chance = 0;
          1: src_chance = 8;
          default: src_chance = 30;
        endcase
        case ($urandom_range(2))
          0: sink_chance = 0;
          1: sink_chance = 8;
          default: sink_chance = 30;
        endcase
      end
      // a request taken at this edge is predicted right away
      if (req_ch.valid && req_ch.ready) begin
        report_q.push_back(next_report(req_ch.payload));
        void'(request_q.pop_front());
      end
      if (req_ch.valid && !req_ch.ready) begin
        // stalled, keep valid and payload as they are
      end else if (src_gap > 0) begin
        src_gap--;
        req_ch.valid <= 1'b0;
      end else if (request_q.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (request_q[0].drain && report_q.size() != 0) begin
        // pressure point: let the block run dry before going on
        req_ch.valid <= 1'b0;
      end else if (!request_q[0].calm && $urandom_range(99) < src_chance) begin
        // idle burst, this one included, its length drawn at random into src_gap
        src_gap = $urandom_range(13);
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid   <= 1'b1;
        req_ch.payload <= request_q[0].rq;
        calm_now       <= request_q[0].calm;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result against the oldest prediction, stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: result with no request outstanding, expected none actual %h",
                   $time, rsp_ch.payload);
        end else begin
          want = report_q.pop_front();
          check_field("out_dx",      want.out_dx,      rsp_ch.payload.out_dx);
          check_field("out_dy",      want.out_dy,      rsp_ch.payload.out_dy);
          check_field("out_wheel",   want.out_wheel,   rsp_ch.payload.out_wheel);
          check_field("out_left",    16'(want.out_left),  16'(rsp_ch.payload.out_left));
          check_field("out_right",   16'(want.out_right), 16'(rsp_ch.payload.out_right));
          check_field("plain_keys",  want.plain_keys,  rsp_ch.payload.plain_keys);
          check_field("ctrl_keys",   want.ctrl_keys,   rsp_ch.payload.ctrl_keys);
          check_field("shift_keys",  want.shift_keys,  rsp_ch.payload.shift_keys);
          check_field("plain_edges", want.plain_edges, rsp_ch.payload.plain_edges);
          check_field("ctrl_edges",  want.ctrl_edges,  rsp_ch.payload.ctrl_edges);
          check_field("shift_edges", want.shift_edges, rsp_ch.payload.shift_edges);
          check_field("count_value", want.count_value, rsp_ch.payload.count_value);
        end
      end
      if (calm_now) begin
        sink_gap = 0;
        rsp_ch.ready <= 1'b1;
      end else if (sink_gap > 0) begin
        sink_gap--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(99) < sink_chance) begin
        sink_gap = $urandom_range(13);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    kmec_pkg::kmec_req_t rq;
    logic [15:0] held;
    int unsigned pick;
    held = '0;

    // directed: counters read as zero straight after reset
    send(read_req(kmec_pkg::GRP_PLAIN, 4'd0));
    send(frame_req(NO_KEYS));
    // every key with both modifiers down: no plain press, ctrl and shift presses
    rq = frame_req(MODS_AND_ALL);
    rq.mouse_dx = 16'sh7FFF; rq.mouse_dy = 16'sh8000; rq.mouse_wheel = 16'shFFFF;
    rq.left_down = 1'b1; rq.right_down = 1'b1;
    send(rq);
    // same mask again, nothing new
    send(frame_req(MODS_AND_ALL));
    rq = frame_req(NO_KEYS);
    rq.mouse_dx = 16'sh8000; rq.mouse_dy = 16'sh7FFF; rq.mouse_wheel = 16'sh0000;
    rq.left_down = 1'b0; rq.right_down = 1'b0;
    send(rq);
    // ctrl with key 0, then ctrl let go while key 0 stays down
    send(frame_req(16'h0011));
    send(frame_req(16'h0001));
    // shift joins on the held key, then only the modifiers
    send(frame_req(16'h0021));
    send(frame_req(16'h0030));
    // all counted keys bare, then released
    send(frame_req(ALL_KEYS));
    send(frame_req(NO_KEYS));
    send(frame_req(16'h8000));
    // reads of each group, the missing group, and the modifier key slots
    send(read_req(kmec_pkg::GRP_PLAIN, 4'd0));
    send(read_req(kmec_pkg::GRP_CTRL, 4'd0));
    send(read_req(kmec_pkg::GRP_SHIFT, 4'd0));
    send(read_req(2'd3, 4'd0));
    send(read_req(kmec_pkg::GRP_PLAIN, 4'(kmec_pkg::CTRL_BIT)));
    send(read_req(kmec_pkg::GRP_CTRL, 4'(kmec_pkg::SHIFT_BIT)));
    send(read_req(kmec_pkg::GRP_SHIFT, 4'(kmec_pkg::CTRL_BIT)));
    send(read_req(kmec_pkg::GRP_PLAIN, 4'd15));
    send(read_req(kmec_pkg::GRP_SHIFT, 4'd15));
    send(read_req(2'd3, 4'd15));

    // random: mostly a keyboard evolving press by press, plus reads and noise
    for (int i = 0; i < 820; i++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        rq = rand_req();
        rq.req_type = kmec_pkg::REQ_READ;
      end else if (pick < 35) begin
        rq = rand_req();
        rq.req_type = kmec_pkg::REQ_FRAME;
      end else begin
        repeat ($urandom_range(1, 3)) held ^= 16'h1 << $urandom_range(15);
        if ($urandom_range(3) == 0) held ^= 16'h1 << kmec_pkg::CTRL_BIT;
        if ($urandom_range(3) == 0) held ^= 16'h1 << kmec_pkg::SHIFT_BIT;
        rq = frame_req(held);
      end
      send(rq, (i == 270 || i == 540), (i >= 680));
    end

    // read every counter back
    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < NUM_KEYS; k++) send(read_req(g[1:0], k[3:0]), 1'b0, 1'b1);
    end

    // wait for the block to go quiet, then let the clock run on before the final check
    wait (rst_ni === 1'b1);
    while (request_q.size() != 0 || req_ch.valid || report_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (report_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, report_q.size());
    end
    if (errors == 0 && report_q.size() == 0) begin
      $display("[keyboard_modifier_edge_counter_top] OK");
    end else begin
      $display("[keyboard_modifier_edge_counter_top] ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("%0t: timeout", $time);
    $display("[keyboard_modifier_edge_counter_top] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/kmec_pkg.sv
rtl/kmec_if.sv
rtl/kmec_front.sv
rtl/kmec_fifo.sv
rtl/kmec_back.sv
rtl/keyboard_modifier_edge_counter_top.sv
verif/testbench.sv
